// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/sdspi_pkg.sv =====
// Types and constants of the SD-card SPI host sequencer.
package sdspi_pkg;
  localparam logic [2:0] ACT_INIT = 3'd0;
  localparam logic [2:0] ACT_READ = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_EJECT = 3'd3;
  localparam logic [2:0] ACT_XCHG = 3'd4;
  localparam logic [2:0] ACT_TICK = 3'd5;

  localparam logic [1:0] RES_OK = 2'd0;
  localparam logic [1:0] RES_ERR = 2'd1;
  localparam logic [1:0] RES_NRDY = 2'd2;
  localparam logic [1:0] RES_PARM = 2'd3;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_WAIT = 2'd1;
  localparam logic [1:0] CFG_DUMMY = 2'd2;

  localparam int BLOCK_BYTES = 512;
  localparam int CARD_REG_BYTES = 16;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] drive;
    logic [31:0] sector;
    logic [15:0] num_blocks;
    logic [7:0] miso_byte;
    logic [7:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic exchange_wanted;
    logic chip_select;
    logic [7:0] read_byte;
    logic read_valid;
    logic write_taken;
    logic done_res;
    logic [1:0] result_code;
    logic not_initialised;
    logic [1:0] card_kind;
    logic fast_clock;
  } out_item_t;
endpackage

// ===== rtl/core/sdspi_if.sv =====
// Valid/ready channel interface carrying one payload.
interface sdspi_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/core/sd_card_spi_host_sequencer_core.sv =====
// SD-card SPI-mode host sequencer: one item per command, byte exchange or tick.
//  channel | dir | payload
//  in_     | in  | in_item_t  (action, drive, sector, num_blocks, miso, write)
//  out_    | out | out_item_t (mosi, cs, read data, completion, status)
//  cfg_    | in  | index 2b, data 24b, write enable
// One item is accepted per cycle; its result is registered and shown in the cycle after acceptance.
// Throughput is set by the single state update; the output register stalls
// input only while it holds an untaken result. Reset is synchronous, active low.
`include "assert_macros.svh"
module sd_card_spi_host_sequencer_core (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [23:0] cfg_data,
  sdspi_if.sink   in_ch,
  sdspi_if.source out_ch
);
  import sdspi_pkg::*;

  localparam logic [4:0] P_IDLE = 5'd0, P_DUMMY = 5'd1, P_PRE = 5'd2, P_SEND = 5'd3,
    P_RESP = 5'd4, P_EXTRA = 5'd5, P_TOKEN = 5'd6, P_DATA = 5'd7, P_CRC = 5'd8,
    P_STUFF = 5'd9, P_RBUSY = 5'd10, P_WTOKEN = 5'd11, P_WDATA = 5'd12, P_WCRC = 5'd13,
    P_WRESP = 5'd14, P_WBUSY = 5'd15, P_WSTOP = 5'd16, P_WSKIP = 5'd17, P_WSBUSY = 5'd18;

  logic [23:0] tmo_r;
  logic [7:0] wlim_r, dummy_r;
  logic [4:0] phase_r, phase_nxt;
  logic [5:0] cidx_r, cidx_nxt;
  logic [31:0] carg_r, carg_nxt;
  logic [2:0] fpos_r, fpos_nxt;
  logic [9:0] bcnt_r, bcnt_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0] tries_r, tries_nxt;
  logic [23:0] tcnt_r, tcnt_nxt;
  logic [7:0] rs_r [5];
  logic [7:0] rs_nxt [5];
  logic [7:0] dresp_r, dresp_nxt;
  logic [1:0] ctype_r, ctype_nxt;
  logic init_r, init_nxt, clks_r, clks_nxt;
  logic eject_r, eject_nxt, v2_r, v2_nxt, loop_r, loop_nxt, fail_r, fail_nxt;
  logic [7:0] ob_r, ob_nxt;
  out_item_t res_nxt, res_r;
  logic ovalid_r;
  logic acc;
  in_item_t it;

  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign acc = in_ch.valid && in_ch.ready;
  assign it = in_ch.payload;
  assign out_ch.valid = ovalid_r;
  assign out_ch.payload = res_r;

  function automatic logic [7:0] frame_byte(input logic [2:0] pos, input logic [5:0] ci,
                                            input logic [31:0] ca);
    logic [7:0] b;
    case (pos)
      3'd0: b = {2'b01, ci};
      3'd1: b = ca[31:24];
      3'd2: b = ca[23:16];
      3'd3: b = ca[15:8];
      3'd4: b = ca[7:0];
      default: b = (ci == 6'd0) ? 8'h95 : ((ci == 6'd8) ? 8'h87 : 8'h01);
    endcase
    return b;
  endfunction

  always_comb begin
    logic done, cmd_end, cmd_ok, taken, rv;
    logic [1:0] code;
    logic [7:0] rd, m;
    logic [9:0] binc;
    done = 1'b0; cmd_end = 1'b0; cmd_ok = 1'b0; taken = 1'b0; rv = 1'b0;
    code = RES_OK; rd = 8'h00; m = it.miso_byte;
    binc = bcnt_r + 10'd1;
    phase_nxt = phase_r; cidx_nxt = cidx_r; carg_nxt = carg_r; fpos_nxt = fpos_r;
    bcnt_nxt = bcnt_r; left_nxt = left_r; tries_nxt = tries_r; tcnt_nxt = tcnt_r;
    rs_nxt = rs_r; dresp_nxt = dresp_r; ctype_nxt = ctype_r; init_nxt = init_r;
    clks_nxt = clks_r; eject_nxt = eject_r; v2_nxt = v2_r; loop_nxt = loop_r;
    fail_nxt = fail_r; ob_nxt = ob_r;
    if (it.action == ACT_XCHG) begin
      unique case (phase_r)
        P_DUMMY: begin
          bcnt_nxt = binc;
          if (binc >= {2'b00, dummy_r}) begin
            cidx_nxt = 6'd0; carg_nxt = '0; phase_nxt = P_PRE; ob_nxt = 8'hFF;
          end
        end
        P_PRE: begin
          fpos_nxt = 3'd0; phase_nxt = P_SEND; ob_nxt = frame_byte(3'd0, cidx_r, carg_r);
        end
        P_SEND: begin
          fpos_nxt = fpos_r + 3'd1;
          if (fpos_nxt < 3'd6) ob_nxt = frame_byte(fpos_nxt, cidx_r, carg_r);
          else if (cidx_r == 6'd12) begin
            phase_nxt = P_STUFF; ob_nxt = 8'hFF;
          end else begin
            tries_nxt = '0; phase_nxt = P_RESP; ob_nxt = 8'hFF;
          end
        end
        P_STUFF: begin
          tries_nxt = '0; phase_nxt = P_RESP; ob_nxt = 8'hFF;
        end
        P_RESP: begin
          rs_nxt[0] = m;
          if (tries_r != 8'hFF) tries_nxt = tries_r + 8'd1;
          if (m != 8'hFF) begin
            if (cidx_r == 6'd8 || cidx_r == 6'd58) begin
              fpos_nxt = 3'd1; phase_nxt = P_EXTRA; ob_nxt = 8'hFF;
            end else begin
              cmd_end = 1'b1; cmd_ok = 1'b1;
            end
          end else if (tries_nxt >= wlim_r) cmd_end = 1'b1;
        end
        P_EXTRA: begin
          if (fpos_r < 3'd5) rs_nxt[fpos_r] = m;
          fpos_nxt = fpos_r + 3'd1;
          if (fpos_nxt >= 3'd5) begin
            cmd_end = 1'b1; cmd_ok = 1'b1;
          end
        end
        P_TOKEN: if (m != 8'hFF) begin
          bcnt_nxt = '0; phase_nxt = P_DATA; ob_nxt = 8'hFF;
        end
        P_DATA: begin
          if (cidx_r != 6'd9) begin
            rd = m; rv = 1'b1;
          end
          bcnt_nxt = binc;
          if (binc >= ((cidx_r == 6'd9) ? 10'(CARD_REG_BYTES) : 10'(BLOCK_BYTES))) begin
            fpos_nxt = 3'd0; phase_nxt = P_CRC; ob_nxt = 8'hFF;
          end
        end
        P_CRC: begin
          fpos_nxt = fpos_r + 3'd1;
          if (fpos_nxt >= 3'd2) begin
            if (cidx_r == 6'd9) begin
              clks_nxt = 1'b1; init_nxt = 1'b1; done = 1'b1;
            end else if (cidx_r == 6'd17) done = 1'b1;
            else begin
              left_nxt = left_r - 16'd1;
              if (left_nxt != 16'd0) begin
                phase_nxt = P_TOKEN; ob_nxt = 8'hFF;
              end else begin
                cidx_nxt = 6'd12; carg_nxt = '0; fpos_nxt = 3'd0; phase_nxt = P_SEND;
                ob_nxt = frame_byte(3'd0, 6'd12, 32'd0);
              end
            end
          end
        end
        P_RBUSY: if (m >= 8'h0F) begin
          done = 1'b1; code = fail_r ? RES_ERR : RES_OK;
        end
        P_WTOKEN: begin
          bcnt_nxt = '0; phase_nxt = P_WDATA; ob_nxt = it.write_byte; taken = 1'b1;
        end
        P_WDATA: begin
          bcnt_nxt = binc;
          if (binc < 10'(BLOCK_BYTES)) begin
            ob_nxt = it.write_byte; taken = 1'b1;
          end else begin
            fpos_nxt = 3'd0; phase_nxt = P_WCRC; ob_nxt = 8'h00;
          end
        end
        P_WCRC: begin
          fpos_nxt = fpos_r + 3'd1;
          if (fpos_nxt >= 3'd2) begin
            phase_nxt = P_WRESP; ob_nxt = 8'hFF;
          end
        end
        P_WRESP: begin
          dresp_nxt = m; phase_nxt = P_WBUSY; ob_nxt = 8'hFF;
        end
        P_WBUSY: if (m == 8'hFF) begin
          if (cidx_r == 6'd24) begin
            done = 1'b1; code = ((dresp_r & 8'h1F) == 8'h05) ? RES_OK : RES_ERR;
          end else begin
            left_nxt = left_r - 16'd1;
            if (left_nxt != 16'd0) begin
              phase_nxt = P_WTOKEN; ob_nxt = 8'hFC;
            end else begin
              phase_nxt = P_WSTOP; ob_nxt = 8'hFD;
            end
          end
        end
        P_WSTOP: begin
          phase_nxt = P_WSKIP; ob_nxt = 8'hFF;
        end
        P_WSKIP: begin
          phase_nxt = P_WSBUSY; ob_nxt = 8'hFF;
        end
        P_WSBUSY: if (m == 8'hFF) done = 1'b1;
        default: ;
      endcase
      // Completion of a command response decides the next command or ends the action.
      if (cmd_end) begin
        case (cidx_r)
          6'd0: begin
            if (eject_r) begin
              init_nxt = 1'b0; clks_nxt = 1'b0; done = 1'b1;
            end else if (!cmd_ok || rs_nxt[0] != 8'h01) begin
              done = 1'b1; code = RES_ERR;
            end else begin
              cidx_nxt = 6'd8; carg_nxt = 32'h000001AA; phase_nxt = P_PRE; ob_nxt = 8'hFF;
            end
          end
          6'd8: begin
            if (cmd_ok && (rs_nxt[4] != 8'hAA || rs_nxt[3] != 8'h01)) begin
              done = 1'b1; code = RES_ERR;
            end else begin
              v2_nxt = cmd_ok; tcnt_nxt = '0; loop_nxt = 1'b1;
              cidx_nxt = 6'd55; carg_nxt = '0; phase_nxt = P_PRE; ob_nxt = 8'hFF;
            end
          end
          6'd55: begin
            cidx_nxt = 6'd41; carg_nxt = 32'h40000000; phase_nxt = P_PRE; ob_nxt = 8'hFF;
          end
          6'd41: begin
            phase_nxt = P_PRE; ob_nxt = 8'hFF;
            if (rs_nxt[0] == 8'h01 && tcnt_r < tmo_r) begin
              cidx_nxt = 6'd55; carg_nxt = '0;
            end else begin
              loop_nxt = 1'b0;
              if (tcnt_r >= tmo_r) begin
                done = 1'b1; code = RES_ERR;
              end else if (v2_r) begin
                cidx_nxt = 6'd58; carg_nxt = '0;
              end else begin
                cidx_nxt = 6'd16; carg_nxt = 32'h00000200;
              end
            end
          end
          6'd58: begin
            phase_nxt = P_PRE; ob_nxt = 8'hFF;
            if (rs_nxt[1][6]) begin
              ctype_nxt = 2'd1; cidx_nxt = 6'd9; carg_nxt = '0;
            end else begin
              cidx_nxt = 6'd16; carg_nxt = 32'h00000200;
            end
          end
          6'd16: begin
            ctype_nxt = v2_r ? 2'd2 : 2'd3; clks_nxt = 1'b1; init_nxt = 1'b1; done = 1'b1;
          end
          6'd9: begin
            phase_nxt = P_TOKEN; ob_nxt = 8'hFF;
          end
          6'd17, 6'd18: begin
            if (rs_nxt[0] != 8'h00) begin
              done = 1'b1; code = RES_ERR;
            end else begin
              phase_nxt = P_TOKEN; ob_nxt = 8'hFF;
            end
          end
          6'd24, 6'd25: begin
            if (rs_nxt[0] != 8'h00) begin
              done = 1'b1; code = RES_ERR;
            end else begin
              phase_nxt = P_WTOKEN; ob_nxt = (cidx_r == 6'd25) ? 8'hFC : 8'hFE;
            end
          end
          6'd12: begin
            fail_nxt = rs_nxt[0] != 8'h00; phase_nxt = P_RBUSY; ob_nxt = 8'hFF;
          end
          default: begin
            done = 1'b1; code = RES_ERR;
          end
        endcase
      end
    end else if (it.action == ACT_TICK) begin
      if (loop_r && tcnt_r != 24'hFFFFFF) tcnt_nxt = tcnt_r + 24'd1;
    end else if (it.action <= ACT_EJECT && phase_r == P_IDLE) begin
      if (it.action == ACT_INIT) begin
        init_nxt = 1'b0; clks_nxt = 1'b0; ctype_nxt = '0; eject_nxt = 1'b0;
        v2_nxt = 1'b0; loop_nxt = 1'b0; bcnt_nxt = '0; ob_nxt = 8'hFF;
        if (dummy_r == 8'd0) begin
          cidx_nxt = 6'd0; carg_nxt = '0; phase_nxt = P_PRE;
        end else phase_nxt = P_DUMMY;
      end else if (it.drive != 8'd0) begin
        done = 1'b1; code = RES_PARM;
      end else if (it.action == ACT_EJECT) begin
        eject_nxt = 1'b1; cidx_nxt = 6'd0; carg_nxt = '0; phase_nxt = P_PRE; ob_nxt = 8'hFF;
      end else if (!init_r) begin
        done = 1'b1; code = RES_NRDY;
      end else begin
        eject_nxt = 1'b0;
        left_nxt = (it.num_blocks > 16'd1) ? it.num_blocks : 16'd1;
        carg_nxt = it.sector; phase_nxt = P_PRE; ob_nxt = 8'hFF;
        if (it.action == ACT_READ) cidx_nxt = (it.num_blocks > 16'd1) ? 6'd18 : 6'd17;
        else cidx_nxt = (it.num_blocks > 16'd1) ? 6'd25 : 6'd24;
      end
    end
    if (done) begin
      phase_nxt = P_IDLE; ob_nxt = 8'hFF;
    end
    res_nxt.mosi_byte = ob_nxt;
    res_nxt.exchange_wanted = phase_nxt != P_IDLE;
    res_nxt.chip_select = phase_nxt == P_IDLE || phase_nxt == P_DUMMY || phase_nxt == P_PRE;
    res_nxt.read_byte = rd;
    res_nxt.read_valid = rv;
    res_nxt.write_taken = taken;
    res_nxt.done_res = done;
    res_nxt.result_code = done ? code : RES_OK;
    res_nxt.not_initialised = !init_nxt;
    res_nxt.card_kind = ctype_nxt;
    res_nxt.fast_clock = clks_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= 24'd1200000; wlim_r <= 8'd9; dummy_r <= 8'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: tmo_r <= cfg_data;
        CFG_WAIT: wlim_r <= cfg_data[7:0];
        CFG_DUMMY: dummy_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE; cidx_r <= '0; carg_r <= '0; fpos_r <= '0; bcnt_r <= '0;
      left_r <= '0; tries_r <= '0; tcnt_r <= '0; dresp_r <= 8'hFF; ctype_r <= '0;
      init_r <= 1'b0; clks_r <= 1'b0; eject_r <= 1'b0; v2_r <= 1'b0; loop_r <= 1'b0;
      fail_r <= 1'b0; ob_r <= 8'hFF; ovalid_r <= 1'b0;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt; cidx_r <= cidx_nxt; carg_r <= carg_nxt; fpos_r <= fpos_nxt;
        bcnt_r <= bcnt_nxt; left_r <= left_nxt; tries_r <= tries_nxt; tcnt_r <= tcnt_nxt;
        dresp_r <= dresp_nxt; ctype_r <= ctype_nxt; init_r <= init_nxt; clks_r <= clks_nxt;
        eject_r <= eject_nxt; v2_r <= v2_nxt; loop_r <= loop_nxt; fail_r <= fail_nxt;
        ob_r <= ob_nxt;
      end
      if (acc) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rs_r <= rs_nxt;
      res_r <= res_nxt;
    end
  end

  `ASSERT_NEXT(a_hold, clk, rst_n, ovalid_r && !out_ch.ready, ovalid_r)
  `ASSERT_IMPLIES(a_idle_cs, clk, rst_n, ovalid_r && !res_r.exchange_wanted, res_r.chip_select)
  `ASSERT_IMPLIES(a_code, clk, rst_n, ovalid_r && !res_r.done_res, res_r.result_code == RES_OK)
  `ASSERT_IMPLIES(a_loop, clk, rst_n, loop_r, phase_r != P_IDLE)
endmodule
